@@ sv/fsl_pkg.sv @@
// Package for the frame slicer with acknowledgement tracking.
// Holds parameter defaults, field widths, request, status and kind codes and the slice info type.
// No dependencies.
package fsl_pkg;

  localparam int SLICE_BYTES_DEF = 1024;
  localparam int GROUP_SLOTS_DEF = 32;

  // wide enough for GROUP_SLOTS * SLICE_BYTES with the default parameters
  localparam int OFF_W   = 20;
  localparam int SLEN_W  = 14;
  localparam int SIDX_W  = 6;
  localparam int FLEN_W  = 16;
  localparam int FNUM_W  = 32;

  localparam logic [1:0] REQ_NEW    = 2'd0;
  localparam logic [1:0] REQ_ACK    = 2'd1;
  localparam logic [1:0] REQ_RESEND = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;

  localparam logic KIND_HDR    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [SLEN_W-1:0] len;
    logic              last;
  } slice_info_t;

endpackage

@@ sv/fsl_slice_calc.sv @@
// Slice length, final-slice detect and next offset for the slice walk.
// Shared by the new-frame and resend sequences. Depends on fsl_pkg.
module fsl_slice_calc import fsl_pkg::*; #(
  parameter int SLICE_BYTES = SLICE_BYTES_DEF
) (
  input  logic [FLEN_W-1:0] frame_len,
  input  logic [OFF_W-1:0]  offset,
  output slice_info_t       info,
  output logic [OFF_W-1:0]  next_offset
);

  localparam logic [OFF_W-1:0] SB = OFF_W'(SLICE_BYTES);

  logic [OFF_W-1:0] rem;

  assign rem          = OFF_W'(frame_len) - offset;
  assign info.len     = (rem < SB) ? rem[SLEN_W-1:0] : SLEN_W'(SLICE_BYTES);
  assign info.last    = (rem <= SB);
  assign next_offset  = offset + SB;

endmodule

@@ sv/frame_slicer_with_ack_tracking.sv @@
// Top level of the frame slicer with selective acknowledgement tracking.
// Sequences slice walks through fsl_slice_calc. Depends on fsl_pkg.
//
//  channel | direction | transaction taken when   | payload
//  in_     | into      | start && !busy           | req_type, frame_len, ack fields
//  out_    | out of    | out_valid (one cycle)    | kind, status, header fields, last
//
// Acks, rejected or empty requests: one result, in the cycle after acceptance.
// New frame of n slices: n results on consecutive cycles, each header registered out of S_NEW.
// Resend: one walk step per slot up to the last pending one, one header per pending slot.
// busy is high for the whole walk; the single offset adder/compare unit sets the pace.
// Reset is synchronous; all slices clear, frame number zero. The receiver cannot stall.
module frame_slicer_with_ack_tracking import fsl_pkg::*; #(
  parameter int SLICE_BYTES = SLICE_BYTES_DEF,
  parameter int GROUP_SLOTS = GROUP_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [FLEN_W-1:0] in_frame_len,
  input  logic [FNUM_W-1:0] in_ack_frame_number,
  input  logic [FLEN_W-1:0] in_ack_slice_index,
  output logic              out_valid,
  output logic              out_kind,
  output logic [1:0]        out_status,
  output logic [FNUM_W-1:0] out_cur_frame_number,
  output logic [FLEN_W-1:0] out_total_len,
  output logic [SIDX_W-1:0] out_slice_index,
  output logic [SLEN_W-1:0] out_slice_len,
  output logic [FLEN_W-1:0] out_slice_offset,
  output logic              out_group_empty,
  output logic              out_last
);

  localparam int IDX_W = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam logic [OFF_W-1:0] FRAME_MAX = OFF_W'(GROUP_SLOTS * SLICE_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_NEW,
    S_RESEND
  } state_t;

  state_t                 state_r;
  logic [GROUP_SLOTS-1:0] pending_r;
  logic [GROUP_SLOTS-1:0] scan_r;
  logic [FNUM_W-1:0]      frame_number_r;
  logic [FLEN_W-1:0]      frame_length_r;
  logic [SIDX_W-1:0]      idx_r;
  logic [OFF_W-1:0]       off_r;

  logic                   out_valid_r;
  logic                   out_kind_r;
  logic [1:0]             out_status_r;
  logic [FNUM_W-1:0]      out_cur_frame_number_r;
  logic [FLEN_W-1:0]      out_total_len_r;
  logic [SIDX_W-1:0]      out_slice_index_r;
  logic [SLEN_W-1:0]      out_slice_len_r;
  logic [FLEN_W-1:0]      out_slice_offset_r;
  logic                   out_group_empty_r;
  logic                   out_last_r;

  slice_info_t            info;
  logic [OFF_W-1:0]       off_nxt;
  logic                   accept;
  logic                   ack_hit;
  logic [GROUP_SLOTS-1:0] ack_pending_nxt;
  logic [IDX_W-1:0]       ack_idx;
  logic                   any_pending;
  logic                   scan_last;

  fsl_slice_calc #(
    .SLICE_BYTES(SLICE_BYTES)
  ) u_calc (
    .frame_len  (frame_length_r),
    .offset     (off_r),
    .info       (info),
    .next_offset(off_nxt)
  );

  assign accept      = start && (state_r == S_IDLE);
  assign any_pending = (pending_r != '0);
  assign ack_idx     = in_ack_slice_index[IDX_W-1:0];
  assign ack_hit     = (in_ack_frame_number == frame_number_r)
                    && (in_ack_slice_index < FLEN_W'(GROUP_SLOTS))
                    && pending_r[ack_idx];
  assign scan_last   = ((scan_r >> 1) == '0);

  always_comb begin
    ack_pending_nxt = pending_r;
    if (ack_hit) begin
      ack_pending_nxt[ack_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      pending_r      <= '0;
      frame_number_r <= '0;
      frame_length_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_kind_r             <= KIND_STATUS;
            out_status_r           <= ST_OK;
            out_cur_frame_number_r <= frame_number_r;
            out_total_len_r        <= '0;
            out_slice_index_r      <= '0;
            out_slice_len_r        <= '0;
            out_slice_offset_r     <= '0;
            out_group_empty_r      <= !any_pending;
            out_last_r             <= 1'b1;
            idx_r                  <= '0;
            off_r                  <= '0;
            case (in_req_type)
              REQ_NEW: begin
                if (any_pending) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_BUSY;
                end else if (OFF_W'(in_frame_len) > FRAME_MAX) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_TOO_LONG;
                end else if (in_frame_len == '0) begin
                  out_valid_r            <= 1'b1;
                  frame_length_r         <= '0;
                  frame_number_r         <= frame_number_r + 1'b1;
                  out_cur_frame_number_r <= frame_number_r + 1'b1;
                end else begin
                  frame_length_r <= in_frame_len;
                  state_r        <= S_NEW;
                end
              end
              REQ_ACK: begin
                out_valid_r       <= 1'b1;
                pending_r         <= ack_pending_nxt;
                out_group_empty_r <= (ack_pending_nxt == '0);
                if (ack_hit && (ack_pending_nxt == '0)) begin
                  frame_number_r         <= frame_number_r + 1'b1;
                  out_cur_frame_number_r <= frame_number_r + 1'b1;
                end
              end
              REQ_RESEND: begin
                if (any_pending) begin
                  scan_r  <= pending_r;
                  state_r <= S_RESEND;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_NEW: begin
          out_valid_r                    <= 1'b1;
          out_kind_r                     <= KIND_HDR;
          out_status_r                   <= ST_OK;
          out_cur_frame_number_r         <= frame_number_r;
          out_total_len_r                <= frame_length_r;
          out_slice_index_r              <= idx_r;
          out_slice_len_r                <= info.len;
          out_slice_offset_r             <= off_r[FLEN_W-1:0];
          out_group_empty_r              <= 1'b0;
          out_last_r                     <= info.last;
          pending_r[idx_r[IDX_W-1:0]]    <= 1'b1;
          idx_r                          <= idx_r + 1'b1;
          off_r                          <= off_nxt;
          if (info.last) begin
            state_r <= S_IDLE;
          end
        end
        S_RESEND: begin
          if (scan_r[0]) begin
            out_valid_r            <= 1'b1;
            out_kind_r             <= KIND_HDR;
            out_status_r           <= ST_OK;
            out_cur_frame_number_r <= frame_number_r;
            out_total_len_r        <= frame_length_r;
            out_slice_index_r      <= idx_r;
            out_slice_len_r        <= info.len;
            out_slice_offset_r     <= off_r[FLEN_W-1:0];
            out_group_empty_r      <= 1'b0;
            out_last_r             <= scan_last;
            if (scan_last) begin
              state_r <= S_IDLE;
            end
          end
          scan_r <= scan_r >> 1;
          idx_r  <= idx_r + 1'b1;
          off_r  <= off_nxt;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_status           = out_status_r;
  assign out_cur_frame_number = out_cur_frame_number_r;
  assign out_total_len        = out_total_len_r;
  assign out_slice_index      = out_slice_index_r;
  assign out_slice_len        = out_slice_len_r;
  assign out_slice_offset     = out_slice_offset_r;
  assign out_group_empty      = out_group_empty_r;
  assign out_last             = out_last_r;

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_STATUS) |-> out_last)
    else $error("status transaction without final mark");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result while sequencer is idle");

  a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_HDR) |-> (out_slice_len != '0) && !out_group_empty)
    else $error("slice header with zero length or empty group");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_number_r != $past(frame_number_r)) |-> (pending_r == '0))
    else $error("frame number advanced with slices pending");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for frame_slicer_with_ack_tracking: directed table, then random traffic.
// Predicts slice headers and status transactions and checks every field. Depends on fsl_pkg.
module tb import fsl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLICE_B       = SLICE_BYTES_DEF;
  localparam int SLOTS         = GROUP_SLOTS_DEF;
  localparam int RANDOM_ITEMS  = 500;
  localparam int DRAIN_CYCLES  = GROUP_SLOTS_DEF + 8;
  localparam int RUN_LIMIT     = 400000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [1:0]        status;
    logic [FNUM_W-1:0] fnum;
    logic [FLEN_W-1:0] total_len;
    logic [SIDX_W-1:0] idx;
    logic [SLEN_W-1:0] len;
    logic [FLEN_W-1:0] offset;
    logic              group_empty;
    logic              last;
  } slice_out_t;

  typedef struct {
    logic [1:0]        req;
    logic [FLEN_W-1:0] flen;
    logic [FNUM_W-1:0] afn;
    logic [FLEN_W-1:0] aidx;
    bit                typed;
    logic [1:0]        st;
    logic [FNUM_W-1:0] fnum;
    logic              ge;
  } request_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_req_type = REQ_NEW;
  logic [FLEN_W-1:0] in_frame_len = '0;
  logic [FNUM_W-1:0] in_ack_frame_number = '0;
  logic [FLEN_W-1:0] in_ack_slice_index = '0;
  logic              out_valid;
  logic              out_kind;
  logic [1:0]        out_status;
  logic [FNUM_W-1:0] out_cur_frame_number;
  logic [FLEN_W-1:0] out_total_len;
  logic [SIDX_W-1:0] out_slice_index;
  logic [SLEN_W-1:0] out_slice_len;
  logic [FLEN_W-1:0] out_slice_offset;
  logic              out_group_empty;
  logic              out_last;

  logic [SLOTS-1:0]  pend_m = '0;
  logic [FNUM_W-1:0] fnum_m = '0;
  logic [FLEN_W-1:0] flen_m = '0;
  logic [6:0]        total_m = '0;

  slice_out_t awaited[$];
  request_t   directed[24];
  int         error_count = 0;
  int         cycle_count = 0;
  int         idle_pct = 12;

  frame_slicer_with_ack_tracking dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_frame_len(in_frame_len),
    .in_ack_frame_number(in_ack_frame_number), .in_ack_slice_index(in_ack_slice_index),
    .out_valid(out_valid), .out_kind(out_kind), .out_status(out_status),
    .out_cur_frame_number(out_cur_frame_number), .out_total_len(out_total_len),
    .out_slice_index(out_slice_index), .out_slice_len(out_slice_len),
    .out_slice_offset(out_slice_offset), .out_group_empty(out_group_empty),
    .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic slice_out_t status_word(input logic [1:0] st);
    slice_out_t s;
    s = '0;
    s.kind = KIND_STATUS;
    s.status = st;
    s.fnum = fnum_m;
    s.group_empty = ~|pend_m;
    s.last = 1'b1;
    return s;
  endfunction

  function automatic slice_out_t header_word(input int idx);
    slice_out_t h;
    int off;
    int rem;
    off = idx * SLICE_B;
    rem = (int'(flen_m) > off) ? int'(flen_m) - off : 0;
    h = '0;
    h.kind = KIND_HDR;
    h.status = ST_OK;
    h.fnum = fnum_m;
    h.total_len = flen_m;
    h.idx = SIDX_W'(idx);
    h.len = SLEN_W'((rem < SLICE_B) ? rem : SLICE_B);
    h.offset = FLEN_W'(off);
    return h;
  endfunction

  task automatic mark_last();
    slice_out_t w;
    w = awaited.pop_back();
    w.last = 1'b1;
    awaited.push_back(w);
  endtask

  task automatic slice_and_track(input request_t r);
    int n;
    case (r.req)
      REQ_NEW: begin
        n = (int'(r.flen) + SLICE_B - 1) / SLICE_B;
        if (|pend_m) begin
          awaited.push_back(status_word(ST_BUSY));
        end else if (n > SLOTS) begin
          awaited.push_back(status_word(ST_TOO_LONG));
        end else begin
          flen_m = r.flen;
          total_m = 7'(n);
          if (n == 0) begin
            fnum_m = fnum_m + 1;
            awaited.push_back(status_word(ST_OK));
          end else begin
            for (int i = 0; i < n; i++) pend_m[i] = 1'b1;
            for (int i = 0; i < n; i++) awaited.push_back(header_word(i));
            mark_last();
          end
        end
      end
      REQ_ACK: begin
        if (r.afn == fnum_m && r.aidx < total_m && r.aidx < SLOTS && pend_m[r.aidx]) begin
          pend_m[r.aidx] = 1'b0;
          if (!(|pend_m)) fnum_m = fnum_m + 1;
        end
        awaited.push_back(status_word(ST_OK));
      end
      REQ_RESEND: begin
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (pend_m[i]) begin
            awaited.push_back(header_word(i));
            n++;
          end
        end
        if (n == 0) awaited.push_back(status_word(ST_OK));
        else mark_last();
      end
      default: awaited.push_back(status_word(ST_OK));
    endcase
  endtask

  function automatic string diff_fields(input slice_out_t g, input slice_out_t e);
    string s;
    s = "";
    if (g.kind !== e.kind) s = {s, $sformatf(" kind %0h/%0h", g.kind, e.kind)};
    if (g.status !== e.status) s = {s, $sformatf(" status %0h/%0h", g.status, e.status)};
    if (g.fnum !== e.fnum) s = {s, $sformatf(" frame %0h/%0h", g.fnum, e.fnum)};
    if (g.total_len !== e.total_len) s = {s, $sformatf(" total %0h/%0h", g.total_len, e.total_len)};
    if (g.idx !== e.idx) s = {s, $sformatf(" index %0h/%0h", g.idx, e.idx)};
    if (g.len !== e.len) s = {s, $sformatf(" len %0h/%0h", g.len, e.len)};
    if (g.offset !== e.offset) s = {s, $sformatf(" offset %0h/%0h", g.offset, e.offset)};
    if (g.group_empty !== e.group_empty) begin
      s = {s, $sformatf(" empty %0h/%0h", g.group_empty, e.group_empty)};
    end
    if (g.last !== e.last) s = {s, $sformatf(" last %0h/%0h", g.last, e.last)};
    return s;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    int lane[$];
    r.req = 2'($urandom_range(0, 3));
    r.flen = 16'($urandom());
    r.afn = $urandom();
    r.aidx = 16'($urandom());
    r.typed = 1'b0;
    r.st = ST_OK;
    r.fnum = '0;
    r.ge = 1'b0;
    pick = $urandom_range(0, 99);
    if (|pend_m) begin
      if (pick < 70) begin
        r.req = REQ_ACK;
        r.afn = fnum_m;
        for (int k = 0; k < SLOTS; k++) if (pend_m[k]) lane.push_back(k);
        if (pick < 6) r.aidx = 16'($urandom_range(0, 2 * SLOTS - 1));
        else r.aidx = 16'(lane[$urandom_range(0, lane.size() - 1)]);
      end else if (pick < 78) begin
        r.req = REQ_RESEND;
      end else if (pick < 85) begin
        r.req = REQ_NEW;
      end
    end else begin
      if (pick < 60) begin
        r.req = REQ_NEW;
        case ($urandom_range(0, 9))
          0: r.flen = '0;
          7: r.flen = 16'($urandom_range(4 * SLICE_B + 1, SLOTS * SLICE_B));
          8: r.flen = 16'($urandom());
          9: r.flen = 16'($urandom_range(1, SLOTS) * SLICE_B);
          default: r.flen = 16'($urandom_range(1, 4 * SLICE_B));
        endcase
      end else if (pick < 70) begin
        r.req = REQ_RESEND;
      end
    end
    return r;
  endfunction

  task automatic send_request(input request_t r);
    in_req_type <= r.req;
    in_frame_len <= r.flen;
    in_ack_frame_number <= r.afn;
    in_ack_slice_index <= r.aidx;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    slice_and_track(r);
    if (r.typed) begin
      void'(awaited.pop_back());
      awaited.push_back('{KIND_STATUS, r.st, r.fnum, '0, '0, '0, '0, r.ge, 1'b1});
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    slice_out_t got;
    string d;
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n && out_valid === 1'b1) begin
      got = {out_kind, out_status, out_cur_frame_number, out_total_len, out_slice_index,
             out_slice_len, out_slice_offset, out_group_empty, out_last};
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction kind %0h index %0d",
                                  out_kind, out_slice_index));
      end else begin
        d = diff_fields(got, awaited.pop_front());
        if (d != "") report_mismatch({"field mismatch (got/exp):", d});
      end
    end
  end

  initial begin
    directed = '{
      '{REQ_RESEND, 16'd0,     32'd0,          16'd0,      1'b1, ST_OK,       32'd1 - 1, 1'b1},
      '{REQ_ACK,    16'd0,     32'd0,          16'd0,      1'b1, ST_OK,       32'd0,     1'b1},
      '{REQ_UNUSED, 16'hffff,  32'hffff_ffff,  16'hffff,   1'b1, ST_OK,       32'd0,     1'b1},
      '{REQ_NEW,    16'd0,     32'd0,          16'd0,      1'b1, ST_OK,       32'd1,     1'b1},
      '{REQ_NEW,    16'hffff,  32'd0,          16'd0,      1'b1, ST_TOO_LONG, 32'd1,     1'b1},
      '{REQ_NEW,    16'd32769, 32'd0,          16'd0,      1'b1, ST_TOO_LONG, 32'd1,     1'b1},
      '{REQ_NEW,    16'd1,     32'd0,          16'd0,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_NEW,    16'd5,     32'd0,          16'd0,      1'b1, ST_BUSY,     32'd1,     1'b0},
      '{REQ_ACK,    16'd0,     32'hffff_ffff,  16'd0,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_ACK,    16'd0,     32'd1,          16'hffff,   1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_ACK,    16'd0,     32'd1,          16'd1,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_RESEND, 16'd0,     32'd0,          16'd0,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_ACK,    16'd0,     32'd1,          16'd0,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_NEW,    16'd1025,  32'd0,          16'd0,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_ACK,    16'd0,     32'd2,          16'd1,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_ACK,    16'd0,     32'd2,          16'd1,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_RESEND, 16'd0,     32'd0,          16'd0,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_ACK,    16'd0,     32'd2,          16'd0,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_NEW,    16'd32768, 32'd0,          16'd0,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_RESEND, 16'd0,     32'd0,          16'd0,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_ACK,    16'd0,     32'd3,          16'd31,     1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_ACK,    16'd0,     32'd3,          16'd32,     1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_UNUSED, 16'd0,     32'd0,          16'd0,      1'b0, ST_OK,       32'd0,     1'b0},
      '{REQ_NEW,    16'd1024,  32'd0,          16'd0,      1'b1, ST_BUSY,     32'd3,     1'b0}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[k]) send_request(directed[k]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < RANDOM_ITEMS / 3) idle_pct = 12;
      else if (i < 2 * RANDOM_ITEMS / 3) idle_pct = 64;
      else idle_pct = 0;
      send_request(random_request());
    end
    start <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
